// File: rtl/ntw_pkg.sv
// shared types, token codes and helper functions for number_to_word_tokens
// no dependencies; imported by the top level

package ntw_pkg;

    localparam int WORD_W          = 6;
    localparam int BIN_W           = 31;
    localparam int BCD_DIGITS      = 10;
    localparam int BCD_W           = 4 * BCD_DIGITS;
    localparam int DAB_STAGES      = 4;
    localparam int STEPS_PER_STAGE = 8;
    localparam int STEPS_LAST      = BIN_W - (DAB_STAGES - 1) * STEPS_PER_STAGE;
    localparam int NUM_GROUPS      = 4;
    localparam int GRP_TOKS        = 5;

    localparam logic [WORD_W-1:0] TOK_EMPTY     = 6'd0;
    localparam logic [WORD_W-1:0] TOK_TEN       = 6'd10;
    localparam logic [WORD_W-1:0] TOK_TENS_BASE = 6'd18;
    localparam logic [WORD_W-1:0] TOK_HUNDRED   = 6'd28;
    localparam logic [WORD_W-1:0] TOK_THOUSAND  = 6'd29;
    localparam logic [WORD_W-1:0] TOK_MILLION   = 6'd30;
    localparam logic [WORD_W-1:0] TOK_BILLION   = 6'd31;
    localparam logic [WORD_W-1:0] TOK_ZERO      = 6'd32;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } dab_t;

    typedef struct packed {
        logic [GRP_TOKS-1:0][WORD_W-1:0] tok;
        logic [2:0]                      cnt;
    } group_t;

    // up to eight shift-and-add-3 steps of binary to bcd conversion
    function automatic dab_t dabble(input dab_t din, input logic [3:0] nsteps);
        dab_t d;
        d = din;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            if (4'(i) < nsteps) begin
                for (int j = 0; j < BCD_DIGITS; j++) begin
                    if (d.bcd[4*j +: 4] >= 4'd5) begin
                        d.bcd[4*j +: 4] = d.bcd[4*j +: 4] + 4'd3;
                    end
                end
                {d.bcd, d.bin} = {d.bcd[BCD_W-2:0], d.bin, 1'b0};
            end
        end
        return d;
    endfunction

    // tokens of one three-digit group, scale word appended when scaled is set and the group is nonzero
    function automatic group_t read_group(input logic [3:0] h, input logic [3:0] t,
                                          input logic [3:0] u, input logic [WORD_W-1:0] scale,
                                          input logic scaled);
        group_t     g;
        logic [2:0] c;
        g.tok = '0;
        c     = '0;
        if (h != 4'd0) begin
            g.tok[c] = {2'b00, h};
            c        = c + 3'd1;
            g.tok[c] = TOK_HUNDRED;
            c        = c + 3'd1;
        end
        if (t >= 4'd2) begin
            g.tok[c] = TOK_TENS_BASE + {2'b00, t};
            c        = c + 3'd1;
            if (u != 4'd0) begin
                g.tok[c] = {2'b00, u};
                c        = c + 3'd1;
            end
        end else if (t != 4'd0 || u != 4'd0) begin
            // one..nineteen
            g.tok[c] = (t[0] ? TOK_TEN : TOK_EMPTY) + {2'b00, u};
            c        = c + 3'd1;
        end
        if (scaled && {h, t, u} != 12'd0) begin
            g.tok[c] = scale;
            c        = c + 3'd1;
        end
        g.cnt = c;
        return g;
    endfunction

    // lowest set bit of a group mask
    function automatic logic [1:0] pick_group(input logic [NUM_GROUPS-1:0] mask);
        logic [1:0] sel;
        sel = '0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                sel = 2'(i);
            end
        end
        return sel;
    endfunction

endpackage

// File: rtl/number_to_word_tokens.sv
// top level of number_to_word_tokens: bcd conversion pipeline and token serializer
// depends on ntw_pkg

// Reads a signed 32-bit number and streams its English reading as word tokens, one
// token per output transfer, with last set on the final token of each number. A
// negative number gives a single empty token, zero gives the single token Zero. The
// number runs through four binary-to-bcd stages and a token serializer, then an output
// register. A number holds the serializer until its last token (of 1 to 16) has been
// emitted; new numbers keep entering the conversion stages meanwhile, and the output
// register lets the next token be formed while the current one is stalled.

module number_to_word_tokens
    import ntw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              value_valid,
    output logic              value_stall,
    input  logic signed [31:0] value,
    output logic              word_valid,
    input  logic              word_stall,
    output logic [WORD_W-1:0] word,
    output logic              last
);

    // conversion stages
    logic               v_reg    [DAB_STAGES];
    dab_t               dab_reg  [DAB_STAGES];
    logic               neg_reg  [DAB_STAGES];
    logic               zero_reg [DAB_STAGES];

    dab_t               din      [DAB_STAGES];
    logic               din_v    [DAB_STAGES];
    logic               din_neg  [DAB_STAGES];
    logic               din_zero [DAB_STAGES];
    logic [DAB_STAGES:0] adv;

    // serializer
    group_t             grp_reg  [NUM_GROUPS];
    group_t             grp_next [NUM_GROUPS];
    logic               ser_valid_reg;
    logic [1:0]         gsel_reg;
    logic [1:0]         gsel_next;
    logic [2:0]         tsel_reg;
    logic [2:0]         tsel_next;
    logic [NUM_GROUPS-1:0] grp_mask;
    logic [NUM_GROUPS-1:0] new_mask;
    logic [NUM_GROUPS-1:0] above;
    logic               end_of_group;
    logic               cur_last;
    logic [WORD_W-1:0]  cur_tok;
    logic               emit;
    logic [BCD_W-1:0]   dig;

    // output register
    logic               word_valid_reg;
    logic [WORD_W-1:0]  word_reg;
    logic               last_reg;
    logic               out_load;

    assign out_load = !word_valid_reg || !word_stall;
    assign emit     = ser_valid_reg && out_load;

    always_comb
    begin
        for (int i = 0; i < NUM_GROUPS; i++) begin
            grp_mask[i] = (grp_reg[i].cnt != 3'd0);
            above[i]    = (2'(i) > gsel_reg);
        end
        cur_tok      = grp_reg[gsel_reg].tok[tsel_reg];
        end_of_group = (tsel_reg == grp_reg[gsel_reg].cnt - 3'd1);
        cur_last     = end_of_group && ((grp_mask & above) == '0);
    end

    // backpressure runs back from the serializer through the conversion stages
    always_comb
    begin
        adv[DAB_STAGES] = !ser_valid_reg || (emit && cur_last);
        for (int k = DAB_STAGES - 1; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign value_stall = !adv[0];

    always_comb
    begin
        for (int k = 0; k < DAB_STAGES; k++) begin
            if (k == 0) begin
                din[k].bcd  = '0;
                din[k].bin  = value[BIN_W-1:0];
                din_v[k]    = value_valid;
                din_neg[k]  = value[31];
                din_zero[k] = (value == 32'sd0);
            end else begin
                din[k]      = dab_reg[k-1];
                din_v[k]    = v_reg[k-1];
                din_neg[k]  = neg_reg[k-1];
                din_zero[k] = zero_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < DAB_STAGES; k++) begin : g_dab
        localparam logic [3:0] NSTEPS = (k == DAB_STAGES - 1) ? 4'(STEPS_LAST)
                                                              : 4'(STEPS_PER_STAGE);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                v_reg[k] <= din_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && din_v[k]) begin
                dab_reg[k]  <= dabble(din[k], NSTEPS);
                neg_reg[k]  <= din_neg[k];
                zero_reg[k] <= din_zero[k];
            end
        end
    end

    // token groups of the number leaving the last conversion stage
    always_comb
    begin
        dig         = dab_reg[DAB_STAGES-1].bcd;
        grp_next[0] = read_group(4'd0, 4'd0, dig[39:36], TOK_BILLION, 1'b1);
        grp_next[1] = read_group(dig[35:32], dig[31:28], dig[27:24], TOK_MILLION, 1'b1);
        grp_next[2] = read_group(dig[23:20], dig[19:16], dig[15:12], TOK_THOUSAND, 1'b1);
        grp_next[3] = read_group(dig[11:8], dig[7:4], dig[3:0], TOK_EMPTY, 1'b0);
        if (neg_reg[DAB_STAGES-1] || zero_reg[DAB_STAGES-1]) begin
            for (int i = 0; i < NUM_GROUPS - 1; i++) begin
                grp_next[i] = '0;
            end
            grp_next[3]        = '0;
            grp_next[3].cnt    = 3'd1;
            grp_next[3].tok[0] = neg_reg[DAB_STAGES-1] ? TOK_EMPTY : TOK_ZERO;
        end
        for (int i = 0; i < NUM_GROUPS; i++) begin
            new_mask[i] = (grp_next[i].cnt != 3'd0);
        end
    end

    always_comb
    begin
        gsel_next = gsel_reg;
        tsel_next = tsel_reg;
        if (adv[DAB_STAGES] && v_reg[DAB_STAGES-1]) begin
            gsel_next = pick_group(new_mask);
            tsel_next = '0;
        end else if (emit && end_of_group) begin
            gsel_next = pick_group(grp_mask & above);
            tsel_next = '0;
        end else if (emit) begin
            tsel_next = tsel_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ser_valid_reg <= 1'b0;
            gsel_reg      <= '0;
            tsel_reg      <= '0;
        end else begin
            if (adv[DAB_STAGES]) begin
                ser_valid_reg <= v_reg[DAB_STAGES-1];
            end
            gsel_reg <= gsel_next;
            tsel_reg <= tsel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[DAB_STAGES] && v_reg[DAB_STAGES-1]) begin
            for (int i = 0; i < NUM_GROUPS; i++) begin
                grp_reg[i] <= grp_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            word_valid_reg <= 1'b0;
        end else if (out_load) begin
            word_valid_reg <= ser_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            word_reg <= cur_tok;
            last_reg <= cur_last;
        end
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    // serializer never points past the tokens of its group
    a_tsel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ser_valid_reg |-> (tsel_reg < grp_reg[gsel_reg].cnt))
        else $error("token index beyond group count");

    // selected group is never an empty one
    a_group_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ser_valid_reg |-> (grp_reg[gsel_reg].cnt != 3'd0))
        else $error("serializer on empty group");

    // empty and zero tokens are always marked last
    a_special_last: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && (word == TOK_EMPTY || word == TOK_ZERO) |-> last)
        else $error("special token not marked last");

    // a token leaving the serializer shows up on the output next cycle
    a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (word_valid && word == $past(cur_tok) && last == $past(cur_last)))
        else $error("output register lost a token");
`endif

endmodule

// File: tb/tb.sv
// self-checking testbench for number_to_word_tokens: directed and random numbers,
// token stream checked against a behavioral reading of each number
// depends on ntw_pkg and rtl/number_to_word_tokens.sv

module tb;
    import ntw_pkg::*;

    localparam int LONG_HOLD      = 200;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 175;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } token_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              value_valid = 1'b0;
    logic              value_stall;
    logic signed [31:0] value = '0;
    logic              word_valid;
    logic              word_stall = 1'b0;
    logic [WORD_W-1:0] word;
    logic              last;

    token_t            pending_tokens[$];
    logic [WORD_W-1:0] spoken[$];
    token_t            head;
    int                error_count = 0;
    int                quiet_cycles = 0;
    logic              idle_on = 1'b1;
    int                hold_req = 0;
    int                hold_taken = 0;
    int                stall_left = 0;

    number_to_word_tokens dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word        (word),
        .last        (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // tokens of one nonzero group of three digits, without its scale word
    function automatic void say_group(int unsigned grp);
        int unsigned hundreds;
        int unsigned rest;
        hundreds = grp / 100;
        rest = grp % 100;
        if (hundreds != 0)
        begin
            spoken.push_back(WORD_W'(hundreds));
            spoken.push_back(TOK_HUNDRED);
        end
        if (rest >= 20)
        begin
            spoken.push_back(TOK_TENS_BASE + WORD_W'(rest / 10));
            if (rest % 10 != 0)
                spoken.push_back(WORD_W'(rest % 10));
        end
        else if (rest != 0)
        begin
            spoken.push_back(WORD_W'(rest));
        end
    endfunction

    // queue the expected token stream for one accepted number
    function automatic void predict_reading(logic signed [31:0] v);
        int unsigned n;
        int unsigned groups[4];
        logic [WORD_W-1:0] scales[4];
        n = v;
        groups[0] = n / 1000000000;
        groups[1] = (n / 1000000) % 1000;
        groups[2] = (n / 1000) % 1000;
        groups[3] = n % 1000;
        scales[0] = TOK_BILLION;
        scales[1] = TOK_MILLION;
        scales[2] = TOK_THOUSAND;
        scales[3] = TOK_EMPTY;
        spoken.delete();
        if (v < 0)
        begin
            spoken.push_back(TOK_EMPTY);
        end
        else if (n == 0)
        begin
            spoken.push_back(TOK_ZERO);
        end
        else
        begin
            for (int g = 0; g < 4; g++)
            begin
                if (groups[g] != 0)
                begin
                    say_group(groups[g]);
                    if (g < 3)
                        spoken.push_back(scales[g]);
                end
            end
        end
        foreach (spoken[i])
            pending_tokens.push_back('{word: spoken[i], last: (i == spoken.size() - 1)});
    endfunction

    function automatic logic signed [31:0] random_number();
        longint n;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom | 32'h8000_0000;
            2: return $urandom_range(0, 999);
            default:
            begin
                n = longint'($urandom_range(0, 2)) * 1000000000;
                for (int g = 0; g < 3; g++)
                begin
                    n = n * 1;
                    if ($urandom_range(0, 3) != 0)
                        n = n + longint'($urandom_range(0, 999)) * (g == 0 ? 1000000 :
                                                                    g == 1 ? 1000 : 1);
                end
                if (n > 2147483647)
                    n = n - 1000000000;
                return 32'(n);
            end
        endcase
    endfunction

    // offers one number and returns at the edge of its transfer, valid still high
    task automatic send_number(input logic signed [31:0] v);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            value_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        value_valid <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (value_stall !== 1'b0);
        predict_reading(v);
    endtask

    // stop offering and wait until every expected token has come out
    task automatic wait_for_readings();
        value_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_special_values();
        send_number(32'sd0);
        send_number(-32'sd1);
        send_number(32'sh8000_0000);
        send_number(32'sh7fff_ffff);
        send_number(32'sd1);
    endtask

    task automatic test_group_shapes();
        send_number(32'sd10);
        send_number(32'sd13);
        send_number(32'sd19);
        send_number(32'sd20);
        send_number(32'sd99);
        send_number(32'sd100);
        send_number(32'sd115);
        send_number(32'sd520);
        send_number(32'sd999);
        send_number(32'sd1000);
        send_number(32'sd1000000);
        send_number(32'sd1000000000);
        send_number(32'sd1001001001);
        send_number(32'sd2000000010);
        send_number(32'sd1234567890);
        send_number(32'sd7000017);
    endtask

    // receiver holds off while long readings keep coming, so the input side backs up
    task automatic test_backpressure();
        idle_on <= 1'b0;
        hold_req <= hold_req + 1;
        for (int i = 0; i < 24; i++)
            send_number(32'(1000000000 + $urandom_range(0, 1147483647)));
        idle_on <= 1'b1;
    endtask

    task automatic test_pause_until_empty();
        wait_for_readings();
        for (int i = 0; i < 10; i++)
            send_number(random_number());
        wait_for_readings();
    endtask

    task automatic test_random_numbers();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // a stretch with no idling on either side
            if (i == 100)
                idle_on <= 1'b0;
            if (i == 140)
                idle_on <= 1'b1;
            send_number(random_number());
        end
    endtask

    // receiver: random stalls, plus one long hold on request
    always @(posedge clk)
    begin
        if (hold_req != hold_taken)
        begin
            hold_taken <= hold_req;
            stall_left <= LONG_HOLD;
            word_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            word_stall <= 1'b1;
        end
        else
        begin
            word_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // compare each token transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && word_valid === 1'b1 && word_stall === 1'b0)
        begin
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: unexpected token: expected none, actual word %0d last %0d",
                         $time, word, last);
                error_count++;
            end
            else
            begin
                head = pending_tokens.pop_front();
                if (word !== head.word)
                begin
                    $display("%0t: word mismatch: expected %0d, actual %0d",
                             $time, head.word, word);
                    error_count++;
                end
                if (last !== head.last)
                begin
                    $display("%0t: last mismatch: expected %0d, actual %0d",
                             $time, head.last, last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((value_valid && value_stall === 1'b0) || (word_valid === 1'b1 && !word_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_values();
        test_group_shapes();
        test_backpressure();
        test_pause_until_empty();
        test_random_numbers();
        wait_for_readings();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
